@@ rtl/islip_pkg.sv @@
// Shared widths, reset values and controller state codes for the iSLIP matcher.
`timescale 1ns / 1ps

package islip_pkg;

    localparam int DATA_W   = 64;   // request and match matrix width on the ports
    localparam int CNT_W    = 4;    // iteration limit and iteration count width
    localparam int OUT_W    = 72;   // match matrix plus count, padded to bytes
    localparam int OUT_PAD  = OUT_W - DATA_W - CNT_W;

    localparam logic [CNT_W-1:0] MAX_ITER_RST = 4'd4;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

endpackage

@@ rtl/islip_crossbar_matcher.sv @@
// Top level of the iSLIP crossbar matcher: controller, pointer state and output register.
`timescale 1ns / 1ps

// Usage:
// The slave stream carries one request matrix per beat (bit input*PORTS+output);
// bits at or above PORTS*PORTS are ignored. The master stream returns one beat per
// request beat: the match matrix in tdata[63:0] and the iteration count in
// tdata[67:64]. The iteration limit is written through i_cfg_we/i_cfg_wdata, by the user
// only while the block is idle (not enforced by the block); it resets to 4.
// One grant/accept round runs per cycle in the lane array, for R rounds per item
// (R <= min(limit, PORTS)); the controller then loads the output register and returns
// to idle, and only there takes the next beat.
// All rounds reuse the single shared round of arbiter lanes.
// The result sits in an output register, so a new request beat is accepted while
// the previous result waits. If the receiver still holds off when the next result
// is ready, the controller holds it and takes no further input.
// Reset clears all grant and accept pointers to zero, empties the output register
// and restores the iteration limit.

module islip_crossbar_matcher #(
    parameter int PORTS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [islip_pkg::DATA_W-1:0] i_s_axis_tdata,   // requests[63:0]
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [islip_pkg::OUT_W-1:0]  o_m_axis_tdata,   // match_matrix[63:0],
                                                           // iterations_used[67:64], zeros
    input  logic                         i_cfg_we,
    input  logic [islip_pkg::CNT_W-1:0]  i_cfg_wdata       // max_iterations
);

    import islip_pkg::*;

    localparam int PW = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int NB = PORTS * PORTS;

    t_state                    r_state, n_state;
    logic [NB-1:0]             r_rem, n_rem;
    logic [NB-1:0]             r_match, n_match;
    logic [CNT_W-1:0]          r_iter, n_iter;
    logic [CNT_W-1:0]          r_max_iter;
    logic [PORTS-1:0][PW-1:0]  r_acc_ptr, n_acc_ptr;
    logic [PORTS-1:0][PW-1:0]  r_gnt_ptr, n_gnt_ptr;
    logic                      r_out_vld, n_out_vld;
    logic [NB-1:0]             r_out_match;
    logic [CNT_W-1:0]          r_out_iter;

    logic [NB-1:0]             w_it_match;
    logic [NB-1:0]             w_it_rem;
    logic [PORTS-1:0][PW-1:0]  w_it_acc_ptr;
    logic [PORTS-1:0][PW-1:0]  w_it_gnt_ptr;
    logic                      w_done;
    logic                      w_out_free;
    logic                      w_in_acc;
    logic                      w_finish;

    islip_iter #(.PORTS(PORTS)) u_iter (
        .i_rem     (r_rem),
        .i_acc_ptr (r_acc_ptr),
        .i_gnt_ptr (r_gnt_ptr),
        .o_match   (w_it_match),
        .o_rem     (w_it_rem),
        .o_acc_ptr (w_it_acc_ptr),
        .o_gnt_ptr (w_it_gnt_ptr)
    );

    assign w_done     = (r_rem == '0) || (r_iter >= r_max_iter);
    assign w_out_free = !r_out_vld || i_m_axis_tready;
    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_finish   = (r_state == S_RUN) && w_done && w_out_free;

    always_comb begin
        n_state   = r_state;
        n_rem     = r_rem;
        n_match   = r_match;
        n_iter    = r_iter;
        n_acc_ptr = r_acc_ptr;
        n_gnt_ptr = r_gnt_ptr;
        n_out_vld = r_out_vld && !i_m_axis_tready;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_rem   = i_s_axis_tdata[NB-1:0];
                    n_match = '0;
                    n_iter  = '0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w_done) begin
                    if (w_out_free) begin
                        n_out_vld = 1'b1;
                        n_state   = S_IDLE;
                    end
                end else begin
                    n_rem   = w_it_rem;
                    n_match = r_match | w_it_match;
                    n_iter  = r_iter + CNT_W'(1);
                    // Pointers move only on accepts of the first round.
                    if (r_iter == '0) begin
                        n_acc_ptr = w_it_acc_ptr;
                        n_gnt_ptr = w_it_gnt_ptr;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_acc_ptr  <= '0;
            r_gnt_ptr  <= '0;
            r_out_vld  <= 1'b0;
            r_max_iter <= MAX_ITER_RST;
        end else begin
            r_state   <= n_state;
            r_acc_ptr <= n_acc_ptr;
            r_gnt_ptr <= n_gnt_ptr;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_max_iter <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_match <= n_match;
        r_iter  <= n_iter;
        if (w_finish) begin
            r_out_match <= r_match;
            r_out_iter  <= r_iter;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{OUT_PAD{1'b0}}, r_out_iter, DATA_W'(r_out_match)};

    // Matched pairs never remain among the open requests.
    a_match_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> ((r_match & r_rem) == '0))
        else $error("matched pair still requested");

    // Every round that runs makes at least one match.
    a_round_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) && !w_done |=> ($countones(r_match) > $countones($past(r_match))))
        else $error("round made no match");

    // A finished item is only handed over when the output slot is free.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_m_axis_tready) |-> !w_finish)
        else $error("result overwritten while stalled");

    // The round count never exceeds the port count.
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_iter <= CNT_W'(PORTS)))
        else $error("iteration count out of range");

endmodule

@@ rtl/islip_rr_arb.sv @@
// Round-robin picker: first set request at or after the pointer, wrapping at N.
`timescale 1ns / 1ps

module islip_rr_arb #(
    parameter  int N  = 8,
    localparam int PW = (N > 1) ? $clog2(N) : 1
) (
    input  logic [N-1:0]  i_req,
    input  logic [PW-1:0] i_ptr,
    output logic          o_vld,
    output logic [PW-1:0] o_idx
);

    always_comb begin
        logic [PW:0] v_pos;
        o_vld = 1'b0;
        o_idx = '0;
        for (int k = 0; k < N; k++) begin
            v_pos = {1'b0, i_ptr} + (PW+1)'(k);
            if (v_pos >= (PW+1)'(N)) begin
                v_pos = v_pos - (PW+1)'(N);
            end
            if (!o_vld && i_req[v_pos[PW-1:0]]) begin
                o_vld = 1'b1;
                o_idx = v_pos[PW-1:0];
            end
        end
    end

endmodule

@@ rtl/islip_iter.sv @@
// One grant/accept round: an arbiter lane per output, one per input, and the merge.
`timescale 1ns / 1ps

module islip_iter #(
    parameter  int PORTS = 8,
    localparam int PW    = (PORTS > 1) ? $clog2(PORTS) : 1,
    localparam int NB    = PORTS * PORTS
) (
    input  logic [NB-1:0]             i_rem,
    input  logic [PORTS-1:0][PW-1:0]  i_acc_ptr,
    input  logic [PORTS-1:0][PW-1:0]  i_gnt_ptr,
    output logic [NB-1:0]             o_match,
    output logic [NB-1:0]             o_rem,
    output logic [PORTS-1:0][PW-1:0]  o_acc_ptr,
    output logic [PORTS-1:0][PW-1:0]  o_gnt_ptr
);

    logic [PORTS-1:0][PORTS-1:0] w_col_req;   // [output][input]
    logic [PORTS-1:0]            w_gnt_vld;
    logic [PORTS-1:0][PW-1:0]    w_gnt_idx;
    logic [PORTS-1:0][PORTS-1:0] w_acc_req;   // [input][output]
    logic [PORTS-1:0]            w_acc_vld;
    logic [PORTS-1:0][PW-1:0]    w_acc_idx;
    logic [PORTS-1:0]            w_col_taken;

    // Grant lanes, one per output column.
    for (genvar j = 0; j < PORTS; j++) begin : g_gnt
        for (genvar i = 0; i < PORTS; i++) begin : g_col
            assign w_col_req[j][i] = i_rem[i*PORTS + j];
        end
        islip_rr_arb #(.N(PORTS)) u_gnt_arb (
            .i_req (w_col_req[j]),
            .i_ptr (i_gnt_ptr[j]),
            .o_vld (w_gnt_vld[j]),
            .o_idx (w_gnt_idx[j])
        );
    end

    // Accept lanes, one per input row; each sees the grants aimed at it.
    for (genvar i = 0; i < PORTS; i++) begin : g_acc
        for (genvar j = 0; j < PORTS; j++) begin : g_row
            assign w_acc_req[i][j] = w_gnt_vld[j] && (w_gnt_idx[j] == PW'(i));
        end
        islip_rr_arb #(.N(PORTS)) u_acc_arb (
            .i_req (w_acc_req[i]),
            .i_ptr (i_acc_ptr[i]),
            .o_vld (w_acc_vld[i]),
            .o_idx (w_acc_idx[i])
        );
    end

    // Merge: build the match bits and strike matched rows and columns.
    always_comb begin
        o_match     = '0;
        w_col_taken = '0;
        for (int i = 0; i < PORTS; i++) begin
            for (int j = 0; j < PORTS; j++) begin
                if (w_acc_vld[i] && (w_acc_idx[i] == PW'(j))) begin
                    o_match[i*PORTS + j] = 1'b1;
                    w_col_taken[j]       = 1'b1;
                end
            end
        end
        for (int i = 0; i < PORTS; i++) begin
            for (int j = 0; j < PORTS; j++) begin
                o_rem[i*PORTS + j] = i_rem[i*PORTS + j] && !w_acc_vld[i] && !w_col_taken[j];
            end
        end
    end

    // Pointer candidates: one past the accepted output, one past the granted input.
    always_comb begin
        for (int i = 0; i < PORTS; i++) begin
            if (!w_acc_vld[i]) begin
                o_acc_ptr[i] = i_acc_ptr[i];
            end else if (w_acc_idx[i] == PW'(PORTS - 1)) begin
                o_acc_ptr[i] = '0;
            end else begin
                o_acc_ptr[i] = w_acc_idx[i] + PW'(1);
            end
        end
        for (int j = 0; j < PORTS; j++) begin
            if (!w_col_taken[j]) begin
                o_gnt_ptr[j] = i_gnt_ptr[j];
            end else if (w_gnt_idx[j] == PW'(PORTS - 1)) begin
                o_gnt_ptr[j] = '0;
            end else begin
                o_gnt_ptr[j] = w_gnt_idx[j] + PW'(1);
            end
        end
    end

endmodule

@@ sim/tb_islip_crossbar_matcher.sv @@
// Self-checking testbench for the iSLIP crossbar matcher with an in-bench matching predictor.
`timescale 1ns / 1ps

module tb_islip_crossbar_matcher;

    import islip_pkg::*;

    localparam int PORTS         = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [CNT_W-1:0]  rounds;
        logic [DATA_W-1:0] pairs;
    } t_match_beat;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [DATA_W-1:0]  i_s_axis_tdata = '0;
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   o_m_axis_tdata;
    logic               i_cfg_we = 1'b0;
    logic [CNT_W-1:0]   i_cfg_wdata = '0;

    islip_crossbar_matcher #(.PORTS(PORTS)) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Predictor state: round-robin pointers and the iteration limit.
    logic [2:0]       accept_ptr [PORTS];
    logic [2:0]       grant_ptr  [PORTS];
    logic [CNT_W-1:0] round_limit;

    logic [DATA_W-1:0] request_queue [$];
    t_match_beat       match_queue [$];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  holds_asked = 0;
    int  holds_done = 0;
    int  hold_left = 0;
    int  quiet_cycles = 0;
    int  fail_cnt = 0;
    bit  req_taken = 1'b0;

    // One cell time of iSLIP; pointers only move on first-round accepts.
    function automatic t_match_beat islip_match(input logic [DATA_W-1:0] reqs);
        logic [DATA_W-1:0] open_reqs;
        t_match_beat       res;
        int                granted [PORTS];
        int                in_idx;
        int                out_idx;
        int                round_cnt;
        open_reqs = reqs;
        res       = '0;
        round_cnt = 0;
        while (open_reqs != '0 && round_cnt < round_limit) begin
            round_cnt++;
            for (int o = 0; o < PORTS; o++) begin
                granted[o] = -1;
                for (int k = 0; k < PORTS; k++) begin
                    in_idx = (k + grant_ptr[o]) % PORTS;
                    if (open_reqs[in_idx*PORTS + o]) begin
                        granted[o] = in_idx;
                        break;
                    end
                end
            end
            for (int i = 0; i < PORTS; i++) begin
                for (int k = 0; k < PORTS; k++) begin
                    out_idx = (k + accept_ptr[i]) % PORTS;
                    if (granted[out_idx] == i) begin
                        res.pairs[i*PORTS + out_idx] = 1'b1;
                        for (int m = 0; m < PORTS; m++) begin
                            open_reqs[i*PORTS + m]       = 1'b0;
                            open_reqs[m*PORTS + out_idx] = 1'b0;
                        end
                        if (round_cnt == 1) begin
                            accept_ptr[i]      = 3'((out_idx + 1) % PORTS);
                            grant_ptr[out_idx] = 3'((i + 1) % PORTS);
                        end
                        break;
                    end
                end
            end
        end
        res.rounds = CNT_W'(round_cnt);
        return res;
    endfunction

    // Monitor: checks result beats, predicts on request beats, runs the watchdog.
    always @(posedge i_clk) begin
        t_match_beat want;
        req_taken = 1'b0;
        if (!i_rst_n) begin
            for (int p = 0; p < PORTS; p++) begin
                accept_ptr[p] = '0;
                grant_ptr[p]  = '0;
            end
            round_limit = MAX_ITER_RST;
        end else begin
            if (i_cfg_we)
                round_limit = i_cfg_wdata;
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (match_queue.size() == 0) begin
                    $error("unexpected result beat, tdata %h", o_m_axis_tdata);
                    fail_cnt++;
                end else begin
                    want = match_queue.pop_front();
                    if (o_m_axis_tdata[DATA_W-1:0] !== want.pairs) begin
                        $error("match_matrix: expected %h, actual %h",
                               want.pairs, o_m_axis_tdata[DATA_W-1:0]);
                        fail_cnt++;
                    end
                    if (o_m_axis_tdata[DATA_W +: CNT_W] !== want.rounds) begin
                        $error("iterations_used: expected %0d, actual %0d",
                               want.rounds, o_m_axis_tdata[DATA_W +: CNT_W]);
                        fail_cnt++;
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                match_queue.push_back(islip_match(i_s_axis_tdata));
                req_taken = 1'b1;
            end
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_islip_crossbar_matcher: errors");
                $finish;
            end
        end
    end

    // Request driver: a beat stays on the bus until it is taken.
    always @(negedge i_clk) begin
        if (i_s_axis_tvalid && !req_taken) begin
            i_s_axis_tvalid <= 1'b1;
        end else if (i_rst_n && request_queue.size() > 0
                     && $urandom_range(99) >= send_idle_pct) begin
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tdata  <= request_queue.pop_front();
        end else begin
            i_s_axis_tvalid <= 1'b0;
        end
    end

    // Result receiver with random stalls and occasional long hold-offs.
    always @(negedge i_clk) begin
        if (holds_done != holds_asked) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [DATA_W-1:0] rand_requests();
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(4))
            0: return a & b & {$urandom, $urandom};
            1: return a & b;
            2: return a | b;
            3: return (64'd1 << $urandom_range(63)) | (64'd1 << $urandom_range(63));
            default: return a;
        endcase
    endfunction

    task automatic wait_idle();
        while (request_queue.size() > 0 || i_s_axis_tvalid || match_queue.size() > 0)
            @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [CNT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input logic [CNT_W-1:0] limit, input int idle_pct,
                             input int stall_pct, input int n_items, input bit long_hold);
        write_limit(limit);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if (long_hold)
            holds_asked++;
        repeat (n_items)
            request_queue.push_back(rand_requests());
        wait_idle();
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset limit: empty, full, corners, permutations, lines, checkerboards.
        request_queue.push_back(64'h0);
        request_queue.push_back({DATA_W{1'b1}});
        request_queue.push_back(64'h1);
        request_queue.push_back(64'h8000_0000_0000_0000);
        request_queue.push_back(64'h8040_2010_0804_0201);
        request_queue.push_back(64'h0102_0408_1020_4080);
        request_queue.push_back(64'h0000_0000_0000_00FF);
        request_queue.push_back(64'h0101_0101_0101_0101);
        request_queue.push_back(64'hAA55_AA55_AA55_AA55);
        request_queue.push_back(64'h55AA_55AA_55AA_55AA);
        request_queue.push_back({DATA_W{1'b1}});
        request_queue.push_back(64'hFF00_0000_0000_0000);
        wait_idle();

        // Zero limit runs no round even with every request set.
        write_limit(4'd0);
        request_queue.push_back({DATA_W{1'b1}});
        request_queue.push_back(64'h8040_2010_0804_0201);
        wait_idle();

        // Limits above the port count behave like an unbounded search.
        write_limit(4'd15);
        request_queue.push_back({DATA_W{1'b1}});
        request_queue.push_back(64'hFEFD_FBF7_EFDF_BF7F);
        wait_idle();

        write_limit(4'd1);
        request_queue.push_back({DATA_W{1'b1}});
        request_queue.push_back(64'h0303_0303_0303_0303);
        wait_idle();

        write_limit(4'd8);
        request_queue.push_back({DATA_W{1'b1}});
        request_queue.push_back(64'hC0C0_0000_0000_0303);
        wait_idle();

        run_phase(4'd1, 0, 0, 70, 1'b0);
        run_phase(4'd8, 78, 0, 60, 1'b0);
        run_phase(4'd15, 0, 78, 60, 1'b0);
        run_phase(4'd2, 27, 27, 70, 1'b0);
        // The receiver holds off while the sender keeps offering beats.
        run_phase(4'd4, 0, 0, 50, 1'b1);
        run_phase(4'd0, 27, 27, 25, 1'b0);
        run_phase(4'd3, 0, 0, 60, 1'b0);
        run_phase(CNT_W'($urandom_range(5, 7)), 78, 78, 40, 1'b0);

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (match_queue.size() != 0) begin
            $error("%0d results never arrived", match_queue.size());
            fail_cnt++;
        end
        if (fail_cnt == 0)
            $display("tb_islip_crossbar_matcher: clean");
        else
            $display("tb_islip_crossbar_matcher: errors");
        $finish;
    end

endmodule
